FILE: rtl/core/tlbp_pkg.sv
// types and constants for the two-level branch predictor with btb
// no dependencies

package tlbp_pkg;

  localparam int unsigned CtrW = 2;
  localparam int unsigned TagW = 30;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENTRIES_LOG2   = 3'd0,
    REG_HISTORY_BITS   = 3'd1,
    REG_TAG_BITS       = 3'd2,
    REG_CTR_RESET      = 3'd3,
    REG_GLOBAL_HISTORY = 3'd4,
    REG_GLOBAL_TABLE   = 3'd5,
    REG_SHARE_MODE     = 3'd6,
    REG_NONE           = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SHARE_NONE   = 2'd0,
    SHARE_PC2    = 2'd1,
    SHARE_PC16   = 2'd2,
    SHARE_PC16_B = 2'd3
  } share_mode_e;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOOK  = 5'b00010,
    S_SWEEP = 5'b00100,
    S_IDX   = 5'b01000,
    S_RD    = 5'b10000
  } state_e;

  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_UPDATE  = 1'b1;

endpackage

FILE: rtl/core/two_level_branch_predictor_btb_core.sv
// two-level branch predictor with direct-mapped btb, iterative sequencer
// depends on tlbp_pkg
//
// channel  dir   handshake                   payload
// in       in    in_valid_i / in_ready_o     command, pc, actual_target, actual_taken,
//                                             earlier_prediction
// out      out   out_valid_o / out_ready_i   predict_taken, predict_target,
//                                             branches_seen, flushes_seen
// cfg      in    cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// predict miss: result registered in the look step, which then returns to idle to accept the next beat
// predict hit and update: look, index and read steps, result registered in the read step
// update that allocates an entry with per-entry counter tables: a sweep step first resets
// all 2**MAX_HISTORY counters of the entry, one counter written per cycle
// reset and config writes clear valid bits at once, no clearing pass; cfg only when idle
// a full output register stalls the sequencer in its last step

module two_level_branch_predictor_btb_core
  import tlbp_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 32,
  parameter int unsigned MAX_HISTORY = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [31:0]        pc_i,
  input  logic [31:0]        actual_target_i,
  input  logic               actual_taken_i,
  input  logic [31:0]        earlier_prediction_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               predict_taken_o,
  output logic [31:0]        predict_target_o,
  output logic [31:0]        branches_seen_o,
  output logic [31:0]        flushes_seen_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned ElMax = $clog2(MAX_ENTRIES + 1) - 1;
  localparam int unsigned SW = (ElMax == 0) ? 1 : ElMax;
  localparam int unsigned NE = 1 << SW;
  localparam int unsigned HB = MAX_HISTORY;
  localparam int unsigned TS = 1 << HB;

  // config
  logic [2:0] el_cfg_q;
  logic [3:0] hb_cfg_q;
  logic [4:0] tb_cfg_q;
  logic [1:0] crs_q;
  logic       gh_q, gt_q;
  logic [1:0] share_q;

  state_e state_q, state_d;

  logic        cmd_q, taken_q;
  logic [31:0] pc_q, target_q, earlier_q;

  logic [NE-1:0]   evalid_q;
  logic [TagW-1:0] etag_q [NE];
  logic [31:0]     etarget_q [NE];
  logic [HB-1:0]   lhist_q [NE];
  logic [HB-1:0]   shist_q;
  logic [TS-1:0]   svalid_q;
  logic [31:0]     branch_q, flush_q;
  logic [HB-1:0]   sweep_q;
  logic [HB-1:0]   idx_q;

  logic [CtrW-1:0] smem [TS];
  logic [CtrW-1:0] lmem [NE*TS];
  logic [CtrW-1:0] srdata_q, lrdata_q;

  logic            out_valid_q, ptaken_q;
  logic [31:0]     ptarget_q, bseen_q, fseen_q;

  // derived lookup fields
  logic [2:0]      el;
  logic [4:0]      tb_lim, tb;
  logic [3:0]      eh;
  logic [HB-1:0]   hmask;
  logic [SW-1:0]   slot;
  logic [31:0]     pc_sh;
  logic [TagW-1:0] tag, tmask;
  logic            hit;
  logic [HB-1:0]   hist, idx;
  logic [31:0]     pc4;
  logic            out_free;
  logic            out_set;
  logic            cfg_we;
  logic [CtrW-1:0] ctr_val, ctr_new;

  always_comb begin
    el = (el_cfg_q > 3'(ElMax)) ? 3'(ElMax) : el_cfg_q;
    tb_lim = 5'd30 - {2'b00, el};
    tb = (tb_cfg_q < tb_lim) ? tb_cfg_q : tb_lim;
    if (hb_cfg_q < 4'd1) begin
      eh = 4'd1;
    end else if (hb_cfg_q > 4'(HB)) begin
      eh = 4'(HB);
    end else begin
      eh = hb_cfg_q;
    end
    hmask = HB'((9'd1 << eh) - 9'd1);
    slot = SW'((pc_q >> 2) & ((32'd1 << el) - 32'd1));
    pc_sh = pc_q >> (6'd2 + {3'b000, el});
    tmask = TagW'((32'd1 << tb) - 32'd1);
    tag = TagW'(pc_sh) & tmask;
    hit = evalid_q[slot] && (etag_q[slot] == tag);
    hist = gh_q ? shist_q : lhist_q[slot];
    idx = hist & hmask;
    if (gt_q) begin
      unique case (share_mode_e'(share_q))
        SHARE_NONE:   idx = idx;
        SHARE_PC2:    idx = idx ^ (HB'(pc_q >> 2) & hmask);
        SHARE_PC16,
        SHARE_PC16_B: idx = idx ^ (HB'(pc_q >> 16) & hmask);
        default:      idx = idx;
      endcase
    end
    pc4 = pc_q + 32'd4;
    out_free = !out_valid_q || out_ready_i;
    out_set = ((state_q == S_LOOK) && (cmd_q == CMD_PREDICT) && !hit && out_free) ||
              ((state_q == S_RD) && out_free);
    ctr_val = gt_q ? (svalid_q[idx_q] ? srdata_q : crs_q) : lrdata_q;
    if (taken_q) begin
      ctr_new = (ctr_val == 2'd3) ? ctr_val : ctr_val + 2'd1;
    end else begin
      ctr_new = (ctr_val == 2'd0) ? ctr_val : ctr_val - 2'd1;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign cfg_we      = cfg_valid_i && cfg_ready_o && (cfg_index_i != REG_NONE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_LOOK;
      S_LOOK: begin
        if (cmd_q == CMD_UPDATE) begin
          state_d = (!hit && !gt_q) ? S_SWEEP : S_IDX;
        end else if (hit) begin
          state_d = S_IDX;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_SWEEP: if (sweep_q == {HB{1'b1}}) state_d = S_IDX;
      S_IDX:   state_d = S_RD;
      S_RD:    if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      el_cfg_q <= 3'd5;
      hb_cfg_q <= 4'd8;
      tb_cfg_q <= 5'd30;
      crs_q    <= 2'd1;
      gh_q     <= 1'b0;
      gt_q     <= 1'b0;
      share_q  <= 2'd0;
      evalid_q <= '0;
      svalid_q <= '0;
      shist_q  <= '0;
      branch_q <= '0;
      flush_q  <= '0;
      sweep_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_ENTRIES_LOG2:   el_cfg_q <= cfg_data_i[2:0];
          REG_HISTORY_BITS:   hb_cfg_q <= cfg_data_i[3:0];
          REG_TAG_BITS:       tb_cfg_q <= cfg_data_i[4:0];
          REG_CTR_RESET:      crs_q    <= cfg_data_i[1:0];
          REG_GLOBAL_HISTORY: gh_q     <= cfg_data_i[0];
          REG_GLOBAL_TABLE:   gt_q     <= cfg_data_i[0];
          REG_SHARE_MODE:     share_q  <= cfg_data_i[1:0];
          default:            el_cfg_q <= el_cfg_q;
        endcase
        evalid_q <= '0;
        svalid_q <= '0;
        shist_q  <= '0;
        branch_q <= '0;
        flush_q  <= '0;
      end
      unique case (state_q)
        S_LOOK: begin
          if (cmd_q == CMD_UPDATE && !hit) evalid_q[slot] <= 1'b1;
        end
        S_SWEEP: sweep_q <= sweep_q + HB'(1);
        S_RD: begin
          if (out_free) begin
            if (cmd_q == CMD_UPDATE) begin
              if (gt_q) svalid_q[idx_q] <= 1'b1;
              if (gh_q) shist_q <= HB'({hist, taken_q});
              branch_q <= branch_q + 32'd1;
              if (taken_q ? (earlier_q != target_q) : (earlier_q != pc4)) begin
                flush_q <= flush_q + 32'd1;
              end
            end
          end
        end
        default: sweep_q <= sweep_q;
      endcase
    end
  end

  // payload and entry fields, valid bits guard every read
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q     <= command_i;
      pc_q      <= pc_i;
      target_q  <= actual_target_i;
      taken_q   <= actual_taken_i;
      earlier_q <= earlier_prediction_i;
    end
    if (state_q == S_LOOK && cmd_q == CMD_UPDATE && !hit) begin
      etag_q[slot] <= tag;
      if (!gh_q) lhist_q[slot] <= '0;
    end
    if (state_q == S_IDX) idx_q <= idx;
    if (state_q == S_LOOK && cmd_q == CMD_PREDICT && !hit && out_free) begin
      ptaken_q  <= 1'b0;
      ptarget_q <= pc4;
      bseen_q   <= branch_q;
      fseen_q   <= flush_q;
    end
    if (state_q == S_RD && out_free) begin
      if (cmd_q == CMD_UPDATE) begin
        etarget_q[slot] <= target_q;
        if (!gh_q) lhist_q[slot] <= HB'({hist, taken_q});
        ptaken_q  <= 1'b0;
        ptarget_q <= '0;
        bseen_q   <= branch_q + 32'd1;
        fseen_q   <= flush_q +
                     ((taken_q ? (earlier_q != target_q) : (earlier_q != pc4)) ? 32'd1 : 32'd0);
      end else begin
        ptaken_q  <= ctr_val[1];
        ptarget_q <= ctr_val[1] ? etarget_q[slot] : pc4;
        bseen_q   <= branch_q;
        fseen_q   <= flush_q;
      end
    end
  end

  // counter memories
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDX) srdata_q <= smem[idx];
    if (state_q == S_RD && out_free && cmd_q == CMD_UPDATE && gt_q) smem[idx_q] <= ctr_new;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDX) lrdata_q <= lmem[{slot, idx}];
    if (state_q == S_SWEEP) begin
      lmem[{slot, sweep_q}] <= crs_q;
    end else if (state_q == S_RD && out_free && cmd_q == CMD_UPDATE && !gt_q) begin
      lmem[{slot, idx_q}] <= ctr_new;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign predict_taken_o  = ptaken_q;
  assign predict_target_o = ptarget_q;
  assign branches_seen_o  = bseen_q;
  assign flushes_seen_o   = fseen_q;

`ifndef SYNTHESIS
  a_sweep_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_SWEEP |-> sweep_q == '0)
    else $error("sweep counter left nonzero");
  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_LOOK)
    else $error("accepted beat not looked up");
  a_rd_after_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD |-> $past(state_q) == S_IDX || $past(state_q) == S_RD)
    else $error("counter used without read");
  a_sweep_local: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWEEP |-> !gt_q && cmd_q == CMD_UPDATE)
    else $error("sweep outside local allocation");
`endif

endmodule
